// ===== sv/qdr_pkg.sv =====
// ----------------------------------------------------------------------------
// qdr_pkg
// Shared types, constants and the arctangent table of the dead reckoning core.
// ----------------------------------------------------------------------------
package qdr_pkg;

    localparam int QUAT_W            = 16;
    localparam int DIST_W            = 24;
    localparam int FWD_W             = 18;
    localparam int POS_OUT_W         = 48;
    localparam int ANGLE_W           = 16;
    localparam int POSITION_WIDTH    = 48;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int DIV_STEPS         = 17;
    localparam int SQRT_STEPS        = 17;
    localparam int CNT_W             = 5;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_QMUL,
        OP_QACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_DMUL,
        OP_DRND,
        OP_DACC,
        OP_SMUL,
        OP_SACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SQRT_DONE,
        OP_COR_INIT,
        OP_COR_STEP,
        OP_COR_DONE,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_QMUL,
        ST_QACC,
        ST_DINIT,
        ST_DSTEP,
        ST_DDONE,
        ST_DMUL,
        ST_DRND,
        ST_DACC,
        ST_SMUL,
        ST_SACC,
        ST_SQINIT,
        ST_SQSTEP,
        ST_SQDONE,
        ST_CINIT,
        ST_CSTEP,
        ST_CDONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] idx;
        logic [1:0]       sel;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
    } status_t;

    // atan(2^-i) in units of pi / 2^31
    function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/qdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// qdr_ctrl
// Sequencer that steps the datapath through products, divisions, position
// update, square root and both angle rotations, and owns the output valid.
// ----------------------------------------------------------------------------
module qdr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  qdr_pkg::status_t status,
    output qdr_pkg::cmd_t    cmd
);

    qdr_pkg::state_t               state_reg, state_next;
    logic [qdr_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]                    sel_reg, sel_next;
    logic                          m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= qdr_pkg::ST_IDLE;
            cnt_reg     <= '0;
            sel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.op       = qdr_pkg::OP_NONE;
        cmd.idx      = cnt_reg;
        cmd.sel      = sel_reg;
        case (state_reg)
            qdr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = qdr_pkg::OP_LOAD;
                    cnt_next   = '0;
                    state_next = qdr_pkg::ST_QMUL;
                end
            end
            qdr_pkg::ST_QMUL: begin
                cmd.op     = qdr_pkg::OP_QMUL;
                state_next = qdr_pkg::ST_QACC;
            end
            qdr_pkg::ST_QACC: begin
                cmd.op = qdr_pkg::OP_QACC;
                if (cnt_reg == qdr_pkg::CNT_W'(7)) begin
                    sel_next   = 2'd0;
                    state_next = qdr_pkg::ST_DINIT;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = qdr_pkg::ST_QMUL;
                end
            end
            qdr_pkg::ST_DINIT: begin
                // all-zero quaternion needs no division
                if (status.n_zero) begin
                    state_next = qdr_pkg::ST_DDONE;
                end else begin
                    cmd.op     = qdr_pkg::OP_DIV_INIT;
                    cnt_next   = '0;
                    state_next = qdr_pkg::ST_DSTEP;
                end
            end
            qdr_pkg::ST_DSTEP: begin
                cmd.op = qdr_pkg::OP_DIV_STEP;
                if (cnt_reg == qdr_pkg::CNT_W'(qdr_pkg::DIV_STEPS - 1)) begin
                    state_next = qdr_pkg::ST_DDONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            qdr_pkg::ST_DDONE: begin
                cmd.op = qdr_pkg::OP_DIV_DONE;
                if (sel_reg == 2'd2) begin
                    sel_next   = 2'd0;
                    state_next = qdr_pkg::ST_DMUL;
                end else begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = qdr_pkg::ST_DINIT;
                end
            end
            qdr_pkg::ST_DMUL: begin
                cmd.op     = qdr_pkg::OP_DMUL;
                state_next = qdr_pkg::ST_DRND;
            end
            qdr_pkg::ST_DRND: begin
                cmd.op     = qdr_pkg::OP_DRND;
                state_next = qdr_pkg::ST_DACC;
            end
            qdr_pkg::ST_DACC: begin
                cmd.op = qdr_pkg::OP_DACC;
                if (sel_reg == 2'd2) begin
                    sel_next   = 2'd0;
                    state_next = qdr_pkg::ST_SMUL;
                end else begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = qdr_pkg::ST_DMUL;
                end
            end
            qdr_pkg::ST_SMUL: begin
                cmd.op     = qdr_pkg::OP_SMUL;
                state_next = qdr_pkg::ST_SACC;
            end
            qdr_pkg::ST_SACC: begin
                cmd.op = qdr_pkg::OP_SACC;
                if (sel_reg == 2'd1) begin
                    state_next = qdr_pkg::ST_SQINIT;
                end else begin
                    sel_next   = 2'd1;
                    state_next = qdr_pkg::ST_SMUL;
                end
            end
            qdr_pkg::ST_SQINIT: begin
                cmd.op     = qdr_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = qdr_pkg::ST_SQSTEP;
            end
            qdr_pkg::ST_SQSTEP: begin
                cmd.op = qdr_pkg::OP_SQRT_STEP;
                if (cnt_reg == qdr_pkg::CNT_W'(qdr_pkg::SQRT_STEPS - 1)) begin
                    state_next = qdr_pkg::ST_SQDONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            qdr_pkg::ST_SQDONE: begin
                cmd.op     = qdr_pkg::OP_SQRT_DONE;
                sel_next   = 2'd0;
                state_next = qdr_pkg::ST_CINIT;
            end
            qdr_pkg::ST_CINIT: begin
                cmd.op     = qdr_pkg::OP_COR_INIT;
                cnt_next   = '0;
                state_next = qdr_pkg::ST_CSTEP;
            end
            qdr_pkg::ST_CSTEP: begin
                cmd.op = qdr_pkg::OP_COR_STEP;
                if (cnt_reg == qdr_pkg::CNT_W'(qdr_pkg::CORDIC_ITERATIONS - 1)) begin
                    state_next = qdr_pkg::ST_CDONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            qdr_pkg::ST_CDONE: begin
                cmd.op = qdr_pkg::OP_COR_DONE;
                if (sel_reg == 2'd1) begin
                    state_next = qdr_pkg::ST_OUT;
                end else begin
                    sel_next   = 2'd1;
                    state_next = qdr_pkg::ST_CINIT;
                end
            end
            qdr_pkg::ST_OUT: begin
                // wait for a free output register
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = qdr_pkg::OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = qdr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qdr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/qdr_datapath.sv =====
// ----------------------------------------------------------------------------
// qdr_datapath
// Shared multiplier, restoring divider, square root and vectoring rotator,
// position accumulators and the output word register.
// ----------------------------------------------------------------------------
module qdr_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  qdr_pkg::cmd_t       cmd,
    output qdr_pkg::status_t    status,
    input  logic signed [15:0]  s_quat_w,
    input  logic signed [15:0]  s_quat_x,
    input  logic signed [15:0]  s_quat_y,
    input  logic signed [15:0]  s_quat_z,
    input  logic signed [23:0]  s_distance_step,
    output logic signed [17:0]  m_forward_x,
    output logic signed [17:0]  m_forward_y,
    output logic signed [17:0]  m_forward_z,
    output logic signed [47:0]  m_position_x,
    output logic signed [47:0]  m_position_y,
    output logic signed [47:0]  m_position_z,
    output logic signed [15:0]  m_heading,
    output logic signed [15:0]  m_pitch,
    output logic                m_degenerate
);

    localparam int PW = qdr_pkg::POSITION_WIDTH;
    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [23:0] dist_reg;
    logic signed [47:0] prod_reg, prod_next;
    logic signed [34:0] n_reg, n_next, numx_reg, numx_next;
    logic signed [34:0] numy_reg, numy_next, numz_reg, numz_next;
    logic [33:0]        rem_reg, rem_next;
    logic [16:0]        qsh_reg, qsh_next, quot_reg, quot_next;
    logic               neg_reg, neg_next;
    logic signed [17:0] fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;
    logic signed [25:0] d_reg, d_next;
    logic signed [PW-1:0] posx_reg, posx_next, posy_reg, posy_next, posz_reg, posz_next;
    logic [33:0]        sq_reg, sq_next, sx_reg, sx_next, sr_reg, sr_next;
    logic [33:0]        sbit_reg, sbit_next;
    logic [17:0]        h_reg, h_next;
    logic signed [27:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [33:0] cz_reg, cz_next;
    logic               czero_reg, czero_next;
    logic signed [15:0] head_reg, head_next, pitch_reg, pitch_next;

    logic signed [23:0] mul_a, mul_b;
    logic signed [17:0] f_sel;
    logic signed [PW-1:0] pos_sel;

    function automatic logic signed [23:0] ext18(input logic signed [17:0] v);
        return {{6{v[17]}}, v};
    endfunction

    function automatic logic signed [23:0] ext16(input logic signed [15:0] v);
        return {{8{v[15]}}, v};
    endfunction

    always_comb begin
        case (cmd.sel)
            2'd0:    f_sel = fx_reg;
            2'd1:    f_sel = fy_reg;
            default: f_sel = fz_reg;
        endcase
        case (cmd.sel)
            2'd0:    pos_sel = posx_reg;
            2'd1:    pos_sel = posy_reg;
            default: pos_sel = posz_reg;
        endcase
    end

    // one shared multiplier for every product
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            qdr_pkg::OP_QMUL: begin
                case (cmd.idx[2:0])
                    3'd0:    begin mul_a = ext16(qw_reg); mul_b = ext16(qw_reg); end
                    3'd1:    begin mul_a = ext16(qx_reg); mul_b = ext16(qx_reg); end
                    3'd2:    begin mul_a = ext16(qy_reg); mul_b = ext16(qy_reg); end
                    3'd3:    begin mul_a = ext16(qz_reg); mul_b = ext16(qz_reg); end
                    3'd4:    begin mul_a = ext16(qx_reg); mul_b = ext16(qy_reg); end
                    3'd5:    begin mul_a = ext16(qw_reg); mul_b = ext16(qz_reg); end
                    3'd6:    begin mul_a = ext16(qx_reg); mul_b = ext16(qz_reg); end
                    default: begin mul_a = ext16(qw_reg); mul_b = ext16(qy_reg); end
                endcase
            end
            qdr_pkg::OP_DMUL: begin
                mul_a = ext18(f_sel);
                mul_b = dist_reg;
            end
            qdr_pkg::OP_SMUL: begin
                mul_a = ext18(f_sel);
                mul_b = ext18(f_sel);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        logic signed [34:0] p35, p2, num_sel, mag;
        logic [48:0]        mval;
        logic [33:0]        t, nn, rb;
        logic signed [17:0] qv, xin, yin;
        logic [47:0]        pm;
        logic [42:0]        rsum;
        logic signed [25:0] dmag;
        logic signed [PW:0] psum, dext;
        logic signed [PW-1:0] sat;
        logic signed [27:0] cx0, cy0, shx, shy;
        logic signed [33:0] ae, zr;
        logic signed [15:0] ang;

        p35     = prod_reg[34:0];
        p2      = p35 <<< 1;
        case (cmd.sel)
            2'd0:    num_sel = numx_reg;
            2'd1:    num_sel = numy_reg;
            default: num_sel = numz_reg;
        endcase
        mag     = num_sel[34] ? -num_sel : num_sel;
        mval    = {mag[32:0], 16'd0} + {17'd0, n_reg[32:1]};
        t       = {rem_reg[32:0], qsh_reg[16]};
        nn      = {1'b0, n_reg[32:0]};
        qv      = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        if (status.n_zero) begin
            qv = (cmd.sel == 2'd0) ? 18'sd65536 : 18'sd0;
        end
        pm      = prod_reg[47] ? 48'(-prod_reg) : 48'(prod_reg);
        rsum    = {1'b0, pm[41:0]} + 43'd32768;
        dmag    = $signed({1'b0, rsum[40:16]});
        dext    = {{(PW + 1 - 26){d_reg[25]}}, d_reg};
        psum    = {pos_sel[PW-1], pos_sel} + dext;
        if (psum[PW] != psum[PW-1]) begin
            sat = psum[PW] ? POS_MIN : POS_MAX;
        end else begin
            sat = psum[PW-1:0];
        end
        rb      = sr_reg + sbit_reg;
        if (cmd.sel == 2'd0) begin
            xin = fx_reg;
            yin = fy_reg;
        end else begin
            xin = $signed(h_reg);
            yin = -fz_reg;
        end
        cx0     = {{2{xin[17]}}, xin, 8'd0};
        cy0     = {{2{yin[17]}}, yin, 8'd0};
        shx     = cx_reg >>> cmd.idx;
        shy     = cy_reg >>> cmd.idx;
        ae      = $signed({2'b00, qdr_pkg::atan_entry(cmd.idx)});
        zr      = cz_reg + 34'sd32768;
        ang     = czero_reg ? 16'sd0 : zr[31:16];

        prod_next  = prod_reg;
        n_next     = n_reg;
        numx_next  = numx_reg;
        numy_next  = numy_reg;
        numz_next  = numz_reg;
        rem_next   = rem_reg;
        qsh_next   = qsh_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        fz_next    = fz_reg;
        d_next     = d_reg;
        posx_next  = posx_reg;
        posy_next  = posy_reg;
        posz_next  = posz_reg;
        sq_next    = sq_reg;
        sx_next    = sx_reg;
        sr_next    = sr_reg;
        sbit_next  = sbit_reg;
        h_next     = h_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        czero_next = czero_reg;
        head_next  = head_reg;
        pitch_next = pitch_reg;

        case (cmd.op)
            qdr_pkg::OP_LOAD: begin
                n_next    = '0;
                numx_next = '0;
                numy_next = '0;
                numz_next = '0;
            end
            qdr_pkg::OP_QMUL, qdr_pkg::OP_DMUL, qdr_pkg::OP_SMUL: begin
                prod_next = mul_a * mul_b;
            end
            qdr_pkg::OP_QACC: begin
                case (cmd.idx[2:0])
                    3'd0, 3'd1: begin
                        n_next    = n_reg + p35;
                        numx_next = numx_reg + p35;
                    end
                    3'd2, 3'd3: begin
                        n_next    = n_reg + p35;
                        numx_next = numx_reg - p35;
                    end
                    3'd4, 3'd5: numy_next = numy_reg + p2;
                    3'd6:       numz_next = numz_reg + p2;
                    default:    numz_next = numz_reg - p2;
                endcase
            end
            qdr_pkg::OP_DIV_INIT: begin
                // magnitude plus half the divisor, quotient fits in 17 bits
                rem_next  = {2'b00, mval[48:17]};
                qsh_next  = mval[16:0];
                quot_next = '0;
                neg_next  = num_sel[34];
            end
            qdr_pkg::OP_DIV_STEP: begin
                if (t >= nn) begin
                    rem_next  = t - nn;
                    quot_next = {quot_reg[15:0], 1'b1};
                end else begin
                    rem_next  = t;
                    quot_next = {quot_reg[15:0], 1'b0};
                end
                qsh_next = {qsh_reg[15:0], 1'b0};
            end
            qdr_pkg::OP_DIV_DONE: begin
                case (cmd.sel)
                    2'd0:    fx_next = qv;
                    2'd1:    fy_next = qv;
                    default: fz_next = qv;
                endcase
            end
            qdr_pkg::OP_DRND: begin
                d_next = prod_reg[47] ? -dmag : dmag;
            end
            qdr_pkg::OP_DACC: begin
                case (cmd.sel)
                    2'd0:    posx_next = sat;
                    2'd1:    posy_next = sat;
                    default: posz_next = sat;
                endcase
            end
            qdr_pkg::OP_SACC: begin
                sq_next = (cmd.sel == 2'd0) ? prod_reg[33:0] : sq_reg + prod_reg[33:0];
            end
            qdr_pkg::OP_SQRT_INIT: begin
                sx_next   = sq_reg;
                sr_next   = '0;
                sbit_next = 34'd1 << 32;
            end
            qdr_pkg::OP_SQRT_STEP: begin
                if (sx_reg >= rb) begin
                    sx_next = sx_reg - rb;
                    sr_next = (sr_reg >> 1) + sbit_reg;
                end else begin
                    sr_next = sr_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
            end
            qdr_pkg::OP_SQRT_DONE: begin
                // remainder above root means round up
                h_next = sr_reg[17:0] + {17'd0, (sx_reg > sr_reg)};
            end
            qdr_pkg::OP_COR_INIT: begin
                czero_next = (xin == 18'sd0) && (yin == 18'sd0);
                if (xin[17]) begin
                    cz_next = yin[17] ? -34'sd2147483648 : 34'sd2147483648;
                    cx_next = -cx0;
                    cy_next = -cy0;
                end else begin
                    cz_next = '0;
                    cx_next = cx0;
                    cy_next = cy0;
                end
            end
            qdr_pkg::OP_COR_STEP: begin
                if (cy_reg > 28'sd0) begin
                    cx_next = cx_reg + shy;
                    cy_next = cy_reg - shx;
                    cz_next = cz_reg + ae;
                end else begin
                    cx_next = cx_reg - shy;
                    cy_next = cy_reg + shx;
                    cz_next = cz_reg - ae;
                end
            end
            qdr_pkg::OP_COR_DONE: begin
                if (cmd.sel == 2'd0) begin
                    head_next = ang;
                end else begin
                    pitch_next = ang;
                end
            end
            default: begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            posx_reg <= '0;
            posy_reg <= '0;
            posz_reg <= '0;
        end else begin
            posx_reg <= posx_next;
            posy_reg <= posy_next;
            posz_reg <= posz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == qdr_pkg::OP_LOAD) begin
            qw_reg   <= s_quat_w;
            qx_reg   <= s_quat_x;
            qy_reg   <= s_quat_y;
            qz_reg   <= s_quat_z;
            dist_reg <= s_distance_step;
        end
        prod_reg  <= prod_next;
        n_reg     <= n_next;
        numx_reg  <= numx_next;
        numy_reg  <= numy_next;
        numz_reg  <= numz_next;
        rem_reg   <= rem_next;
        qsh_reg   <= qsh_next;
        quot_reg  <= quot_next;
        neg_reg   <= neg_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        fz_reg    <= fz_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        sx_reg    <= sx_next;
        sr_reg    <= sr_next;
        sbit_reg  <= sbit_next;
        h_reg     <= h_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        czero_reg <= czero_next;
        head_reg  <= head_next;
        pitch_reg <= pitch_next;
    end

    // output word register
    always_ff @(posedge aclk) begin
        logic signed [64:0] ex, ey, ez;
        ex = {{(65 - PW){posx_reg[PW-1]}}, posx_reg};
        ey = {{(65 - PW){posy_reg[PW-1]}}, posy_reg};
        ez = {{(65 - PW){posz_reg[PW-1]}}, posz_reg};
        if (cmd.op == qdr_pkg::OP_OUT) begin
            m_forward_x  <= fx_reg;
            m_forward_y  <= fy_reg;
            m_forward_z  <= fz_reg;
            m_position_x <= ex[47:0];
            m_position_y <= ey[47:0];
            m_position_z <= ez[47:0];
            m_heading    <= head_reg;
            m_pitch      <= pitch_reg;
            m_degenerate <= status.n_zero;
        end
    end

    assign status.n_zero = (n_reg == 35'sd0);

endmodule

// ===== sv/quaternion_dead_reckoning_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_dead_reckoning_core
// Dead reckoning from an orientation quaternion and a distance per word.
// ----------------------------------------------------------------------------
// Input channel s_*: one word carries a Q1.14 quaternion and a Q8.16 distance.
// Output channel m_*: one word per input, with the forward column of the
// rotation matrix (Q1.16), the saturating Q32.16 position after the step,
// heading and pitch in units of pi/32768 and a degenerate flag for the
// all-zero quaternion (forward taken as 1,0,0).
// The sequencer handles one word at a time and takes the next word only after
// the last one has reached the output register; the divisions are skipped
// for the all-zero quaternion.
// The time goes to three 17-step restoring divisions, a 17-step square root
// and two CORDIC runs of 16 iterations; all products share one 24x24 multiplier.
// The result sits in an output register, so a new word is accepted while a
// stalled result waits; the next result holds in its last step until the
// output register is free.
// Reset clears the position to zero and drops m_valid.
// ----------------------------------------------------------------------------
module quaternion_dead_reckoning_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_quat_w,
    input  logic signed [15:0]  s_quat_x,
    input  logic signed [15:0]  s_quat_y,
    input  logic signed [15:0]  s_quat_z,
    input  logic signed [23:0]  s_distance_step,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [17:0]  m_forward_x,
    output logic signed [17:0]  m_forward_y,
    output logic signed [17:0]  m_forward_z,
    output logic signed [47:0]  m_position_x,
    output logic signed [47:0]  m_position_y,
    output logic signed [47:0]  m_position_z,
    output logic signed [15:0]  m_heading,
    output logic signed [15:0]  m_pitch,
    output logic                m_degenerate
);

    qdr_pkg::cmd_t    cmd;
    qdr_pkg::status_t status;

    qdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    qdr_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_quat_w        (s_quat_w),
        .s_quat_x        (s_quat_x),
        .s_quat_y        (s_quat_y),
        .s_quat_z        (s_quat_z),
        .s_distance_step (s_distance_step),
        .m_forward_x     (m_forward_x),
        .m_forward_y     (m_forward_y),
        .m_forward_z     (m_forward_z),
        .m_position_x    (m_position_x),
        .m_position_y    (m_position_y),
        .m_position_z    (m_position_z),
        .m_heading       (m_heading),
        .m_pitch         (m_pitch),
        .m_degenerate    (m_degenerate)
    );

endmodule

// ===== sv/qdr_checker.sv =====
// ----------------------------------------------------------------------------
// qdr_checker
// Port-level checks of the dead reckoning core, bound to the top level.
// ----------------------------------------------------------------------------
module qdr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [17:0]  m_forward_x,
    input logic signed [17:0]  m_forward_y,
    input logic signed [17:0]  m_forward_z,
    input logic signed [47:0]  m_position_x,
    input logic                m_degenerate
);

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_forward_x) && $stable(m_position_x))
        else $error("stalled result changed");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a word while busy");

    // degenerate quaternion gives the unit x forward vector
    a_degen_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_forward_x == 18'sd65536 &&
                                    m_forward_y == 18'sd0 && m_forward_z == 18'sd0)
        else $error("degenerate word with wrong forward vector");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");

endmodule

bind quaternion_dead_reckoning_core qdr_checker u_qdr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_forward_x  (m_forward_x),
    .m_forward_y  (m_forward_y),
    .m_forward_z  (m_forward_z),
    .m_position_x (m_position_x),
    .m_degenerate (m_degenerate)
);

// ===== sim/quaternion_dead_reckoning_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_dead_reckoning_core_test
// Self-checking bench: a directed table (degenerate, identity, half turn,
// vertical forward, field extremes) and then random words, with bursty input
// and a stalling output. Every result is checked against an in-bench model.
// ----------------------------------------------------------------------------
module quaternion_dead_reckoning_core_test;

    localparam int N_RANDOM   = 1850;
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_LEN   = 1500;

    typedef struct {
        logic signed [17:0] fx, fy, fz;
        logic signed [47:0] px, py, pz;
        logic signed [15:0] hd, pt;
        logic               dg;
    } nav_t;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic signed [23:0] d;
        bit                 typed;
        logic signed [17:0] fx, fy, fz;
        logic signed [15:0] hd, pt;
        logic               dg;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic signed [23:0] s_distance_step = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [17:0] m_forward_x, m_forward_y, m_forward_z;
    logic signed [47:0] m_position_x, m_position_y, m_position_z;
    logic signed [15:0] m_heading, m_pitch;
    logic m_degenerate;

    row_t   cur_row;
    nav_t   nav_q[$];
    longint pos_x, pos_y, pos_z;
    int     errors = 0;
    int     idle_cycles = 0;
    bit     hold_req = 1'b0;

    longint atan_tab[24] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

    always #1 aclk = ~aclk;

    quaternion_dead_reckoning_core dut (.*);

    // rounded quotient, ties away from zero
    function automatic longint div_near(longint num, longint den);
        longint m, q;
        m = num < 0 ? -num : num;
        q = (m + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint sqrt_near(longint v);
        longint r, b, x;
        r = 0;
        b = 64'sd1 <<< 62;
        x = v;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic logic signed [15:0] angle_of(longint y, longint x);
        longint z, cx, cy, sx, sy;
        z = 0;
        cx = x * 256;
        cy = y * 256;
        if (x == 0 && y == 0) return '0;
        if (cx < 0) begin
            z = (cy >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < qdr_pkg::CORDIC_ITERATIONS; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy > 0) begin
                cx += sy; cy -= sx; z += atan_tab[i];
            end else begin
                cx -= sy; cy += sx; z -= atan_tab[i];
            end
        end
        return 16'((z + (64'sd1 <<< 15)) >>> 16);
    endfunction

    function automatic longint add_clamped(longint p, longint d);
        longint maxv, minv;
        maxv = (64'sd1 <<< (qdr_pkg::POSITION_WIDTH - 1)) - 1;
        minv = -maxv - 1;
        if (d > 0 && p > maxv - d) return maxv;
        if (d < 0 && p < minv - d) return minv;
        return p + d;
    endfunction

    function automatic nav_t advance_position(row_t r);
        nav_t   o;
        longint w, x, y, z, d, n, fx, fy, fz;
        w = r.w; x = r.x; y = r.y; z = r.z; d = r.d;
        n = w * w + x * x + y * y + z * z;
        if (n == 0) begin
            fx = 65536; fy = 0; fz = 0;
        end else begin
            fx = div_near((n - 2 * (y * y + z * z)) * 65536, n);
            fy = div_near(2 * (x * y + w * z) * 65536, n);
            fz = div_near(2 * (x * z - w * y) * 65536, n);
        end
        pos_x = add_clamped(pos_x, div_near(fx * d, 65536));
        pos_y = add_clamped(pos_y, div_near(fy * d, 65536));
        pos_z = add_clamped(pos_z, div_near(fz * d, 65536));
        o.fx = 18'(fx); o.fy = 18'(fy); o.fz = 18'(fz);
        o.px = 48'(pos_x); o.py = 48'(pos_y); o.pz = 48'(pos_z);
        o.hd = angle_of(fy, fx);
        o.pt = angle_of(-fz, sqrt_near(fx * fx + fy * fy));
        o.dg = (n == 0);
        if (r.typed) begin
            o.fx = r.fx; o.fy = r.fy; o.fz = r.fz;
            o.hd = r.hd; o.pt = r.pt; o.dg = r.dg;
        end
        return o;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // input words accepted and output words checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) nav_q.push_back(advance_position(cur_row));
            if (m_valid && m_ready) begin
                if (nav_q.size() == 0) begin
                    $error("output word with nothing expected");
                    errors++;
                end else begin
                    nav_t e;
                    e = nav_q.pop_front();
                    check_field("forward_x", e.fx, m_forward_x);
                    check_field("forward_y", e.fy, m_forward_y);
                    check_field("forward_z", e.fz, m_forward_z);
                    check_field("position_x", e.px, m_position_x);
                    check_field("position_y", e.py, m_position_y);
                    check_field("position_z", e.pz, m_position_z);
                    check_field("heading", e.hd, m_heading);
                    check_field("pitch", e.pt, m_pitch);
                    check_field("degenerate", e.dg, m_degenerate);
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int mode;
        mode = 0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 300) != 0) ? m_ready
                                    : ~m_ready;
            endcase
            @(posedge aclk);
        end
    end

    int burst_left = 0;

    task automatic send_word(row_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_quat_w <= r.w;
        s_quat_x <= r.x;
        s_quat_y <= r.y;
        s_quat_z <= r.z;
        s_distance_step <= r.d;
        cur_row <= r;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 64)) - 16'sd32;
            3: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    row_t directed[$];

    function automatic row_t mk(int w, int x, int y, int z, int d);
        row_t r;
        r = '{w: 16'(w), x: 16'(x), y: 16'(y), z: 16'(z), d: 24'(d), typed: 1'b0,
              fx: '0, fy: '0, fz: '0, hd: '0, pt: '0, dg: 1'b0};
        return r;
    endfunction

    function automatic row_t mk_typed(int w, int x, int y, int z, int d,
                                      int fx, int fy, int fz, int hd, int pt,
                                      bit dg);
        row_t r;
        r = mk(w, x, y, z, d);
        r.typed = 1'b1;
        r.fx = 18'(fx); r.fy = 18'(fy); r.fz = 18'(fz);
        r.hd = 16'(hd); r.pt = 16'(pt); r.dg = dg;
        return r;
    endfunction

    initial begin
        row_t r;
        pos_x = 0; pos_y = 0; pos_z = 0;
        cur_row = mk(0, 0, 0, 0, 0);
        // all-zero quaternion after reset
        directed.push_back(mk_typed(0, 0, 0, 0, 8388607, 65536, 0, 0, 0, 0, 1));
        directed.push_back(mk_typed(0, 0, 0, 0, -8388608, 65536, 0, 0, 0, 0, 1));
        // identity and its negation
        directed.push_back(mk_typed(16384, 0, 0, 0, 65536, 65536, 0, 0, 0, 0, 0));
        directed.push_back(mk_typed(-32768, 0, 0, 0, 1, 65536, 0, 0, 0, 0, 0));
        // half turn about z: heading exactly pi wraps negative
        directed.push_back(mk_typed(0, 0, 0, 16384, 100, -65536, 0, 0, -32768, 0, 0));
        // forward straight down / up: no heading plane
        directed.push_back(mk_typed(16384, 0, 16384, 0, 5000, 0, 0, -65536, 0, 16384, 0));
        directed.push_back(mk_typed(16384, 0, -16384, 0, 5000, 0, 0, 65536, 0, -16384, 0));
        directed.push_back(mk(32767, 32767, 32767, 32767, 8388607));
        directed.push_back(mk(-32768, -32768, -32768, -32768, -8388608));
        directed.push_back(mk(-32768, 32767, -32768, 32767, 0));
        directed.push_back(mk(1, 0, 0, 0, -1));
        directed.push_back(mk(0, 1, 0, 0, 1));
        directed.push_back(mk(0, 0, 1, 0, 8388607));
        directed.push_back(mk(0, 0, 0, -1, 8388607));
        directed.push_back(mk(11585, 0, 0, 11585, 65536));
        directed.push_back(mk(11585, 0, 0, -11585, 65536));
        directed.push_back(mk(1, -32768, 32767, 1, -12345));
        directed.push_back(mk(-1, 1, -1, 1, 4096));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_word(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) hold_req = 1'b1;
            if ($urandom_range(0, 49) == 0) r = mk(0, 0, 0, 0, 0);
            else r = mk(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 0);
            case ($urandom_range(0, 3))
                0: r.d = 24'($urandom_range(0, 512)) - 24'sd256;
                1: r.d = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                default: r.d = 24'($urandom);
            endcase
            send_word(r);
        end
        s_valid <= 1'b0;

        while (nav_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
